// ===== hw/rtl/rpc_pkg.sv =====
// rpc_pkg: shared constants and types of the rectangle polyline clipper
// vertex class bits, register indexes and per-point flag word
// no dependencies
package rpc_pkg;

  localparam int MASK_W  = 6;
  localparam int CFG_IDX_W = 2;

  localparam logic [MASK_W-1:0] CLS_IN     = 6'd1;
  localparam logic [MASK_W-1:0] CLS_OUT    = 6'd2;
  localparam logic [MASK_W-1:0] CLS_LEFT   = 6'd4;
  localparam logic [MASK_W-1:0] CLS_TOP    = 6'd8;
  localparam logic [MASK_W-1:0] CLS_RIGHT  = 6'd16;
  localparam logic [MASK_W-1:0] CLS_BOTTOM = 6'd32;
  localparam logic [MASK_W-1:0] CLS_EDGES  = CLS_LEFT | CLS_TOP | CLS_RIGHT | CLS_BOTTOM;

  localparam logic [CFG_IDX_W-1:0] REG_X_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_MIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_MAX = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_MAX = 2'd3;

  typedef struct packed {
    logic valid;
    logic start;
    logic stop;
  } pt_flags_t;

endpackage

// ===== hw/rtl/rpc_scale.sv =====
// rpc_scale: iterative trunc(d*n/q) with the result magnitude saturated to |d|
// shift-add multiply then restoring divide, one bit per cycle, separate add/sub paths
// no dependencies
module rpc_scale #(
  parameter int MW = 33
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [MW-1:0] d,
  input  logic signed [MW-1:0] n,
  input  logic signed [MW-1:0] q,
  output logic                 done,
  output logic signed [MW-1:0] res
);

  localparam int CW = $clog2(MW);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_DONE} sc_state_t;

  sc_state_t       state;
  logic [2*MW-1:0] acc;
  logic [MW-1:0]   ad_r;
  logic [MW-1:0]   aq_r;
  logic [MW-1:0]   mag_r;
  logic            neg_r;
  logic [CW-1:0]   cnt;

  logic [MW-1:0]   ad, an, aq;
  logic [MW:0]     msum;
  logic [2*MW-1:0] acc_mul;
  logic [MW:0]     r2;
  logic [MW:0]     rsub;
  logic            ge;
  logic [2*MW-1:0] acc_div;
  logic            cnt_last;

  assign ad = d[MW-1] ? (~d + 1'b1) : d;
  assign an = n[MW-1] ? (~n + 1'b1) : n;
  assign aq = q[MW-1] ? (~q + 1'b1) : q;

  // multiply step: add |d| when the low bit is set, shift right
  assign msum    = {1'b0, acc[2*MW-1:MW]} + {1'b0, (acc[0] ? ad_r : {MW{1'b0}})};
  assign acc_mul = {msum, acc[MW-1:1]};

  // divide step: upper half is the partial remainder, quotient shifts into the low end
  assign r2      = {acc[2*MW-1:MW], acc[MW-1]};
  assign ge      = r2 >= {1'b0, aq_r};
  assign rsub    = r2 - {1'b0, aq_r};
  assign acc_div = {(ge ? rsub[MW-1:0] : r2[MW-1:0]), acc[MW-2:0], ge};

  assign cnt_last = (cnt == CW'(MW - 1));
  assign done     = (state == S_DONE);
  assign res      = neg_r ? $signed(~mag_r + 1'b1) : $signed(mag_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            neg_r <= (d[MW-1] ^ n[MW-1]) ^ q[MW-1];
            ad_r  <= ad;
            aq_r  <= aq;
            cnt   <= '0;
            if (an >= aq) begin
              mag_r <= ad;
              state <= S_DONE;
            end else begin
              acc   <= {{MW{1'b0}}, an};
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          acc <= acc_mul;
          if (cnt_last) begin
            cnt   <= '0;
            state <= S_DIV;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DIV: begin
          acc <= acc_div;
          if (cnt_last) begin
            mag_r <= acc_div[MW-1:0];
            state <= S_DONE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/rect_polyline_clipper_unit.sv =====
// rect_polyline_clipper_unit: clips a polyline against an axis-aligned rectangle
// uses rpc_pkg and the rpc_scale multiply-divide unit
//
// Vertices come in one word at a time (signed fixed point, COORD_WIDTH bits, Q16.16
// by default) and the inside parts leave as point words marked start or end of a
// piece; the last vertex of a polyline always yields at least one word, carrying
// the accumulated position mask. The block takes one vertex at a time; each boundary
// cut goes through the one shared rpc_scale unit, and a vertex can need up to four
// cuts. Rectangle registers are written through cfg_we/cfg_index/cfg_data; the user
// must write them only while idle, as the block itself does not enforce it.
module rect_polyline_clipper_unit #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [rpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_WIDTH-1:0]        cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_y,
  input  logic                          last_point,
  input  logic                          ring_interior,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] out_x,
  output logic signed [COORD_WIDTH-1:0] out_y,
  output logic                          point_valid,
  output logic                          starts_piece,
  output logic                          ends_piece,
  output logic                          piece_interior,
  output logic [rpc_pkg::MASK_W-1:0]    position_mask,
  output logic                          last_of_run
);

  localparam int W  = COORD_WIDTH;
  localparam int MW = COORD_WIDTH + 1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PLAN, ST_CUT_X, ST_CUT_XW, ST_CUT_Y, ST_CUT_YW, ST_POST, ST_FINISH, ST_EMIT
  } st_t;

  typedef enum logic [2:0] {
    U_IN_OUT, U_OO_A, U_OO_B, U_OUT_IN, U_OUT_EDGE, U_EDGE_OUT
  } cut_use_t;

  st_t      state;
  cut_use_t use_r;

  logic signed [W-1:0] x_min, y_min, x_max, y_max;
  logic signed [W-1:0] prev_x, prev_y;
  logic [rpc_pkg::MASK_W-1:0] prev_class, seen_mask, cur_cls, pa_cls, mask_out;
  logic first_vertex;
  logic signed [W-1:0] cur_x, cur_y;
  logic last_r, ring_r;
  logic signed [W-1:0] wx, wy, tx, ty, ax, ay, lim_r;
  logic signed [W-1:0] ent_x [2];
  logic signed [W-1:0] ent_y [2];
  rpc_pkg::pt_flags_t  ent_f [2];
  logic [1:0] ent_n;
  logic       emit_idx;

  function automatic logic [rpc_pkg::MASK_W-1:0] classify(input logic signed [W-1:0] x,
                                                          input logic signed [W-1:0] y);
    logic [rpc_pkg::MASK_W-1:0] c;
    c = '0;
    if (x > x_min && x < x_max && y > y_min && y < y_max) begin
      c = rpc_pkg::CLS_IN;
    end else if (x < x_min || x > x_max || y < y_min || y > y_max) begin
      c = rpc_pkg::CLS_OUT;
    end else begin
      if (x == x_min) c = c | rpc_pkg::CLS_LEFT;
      else if (x == x_max) c = c | rpc_pkg::CLS_RIGHT;
      if (y == y_min) c = c | rpc_pkg::CLS_BOTTOM;
      else if (y == y_max) c = c | rpc_pkg::CLS_TOP;
    end
    return c;
  endfunction

  function automatic logic [3:0] sides(input logic signed [W-1:0] x,
                                       input logic signed [W-1:0] y);
    return {y > y_max, y < y_min, x > x_max, x < x_min};
  endfunction

  function automatic logic same_edge(input logic [rpc_pkg::MASK_W-1:0] a,
                                     input logic [rpc_pkg::MASK_W-1:0] b);
    return (a & b & rpc_pkg::CLS_EDGES) != '0;
  endfunction

  function automatic logic is_edge(input logic [rpc_pkg::MASK_W-1:0] a);
    return (a & rpc_pkg::CLS_EDGES) != '0;
  endfunction

  function automatic logic signed [MW-1:0] dif(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    return {a[W-1], a} - {b[W-1], b};
  endfunction

  logic [rpc_pkg::MASK_W-1:0] cls_cur, cls_w;
  logic x_lo, x_hi, y_lo, y_hi, x_go, y_go;
  logic signed [W-1:0] xlim, ylim;
  logic sc_start, sc_done;
  logic signed [MW-1:0] sc_d, sc_n, sc_q, sc_res;
  logic w_moved_a, w_moved_c;

  assign cls_cur = classify(cur_x, cur_y);
  assign cls_w   = classify(wx, wy);

  assign x_lo = wx < x_min;
  assign x_hi = wx > x_max;
  assign xlim = x_lo ? x_min : x_max;
  assign x_go = (x_lo || x_hi) && (wx != tx);
  assign y_lo = wy < y_min;
  assign y_hi = wy > y_max;
  assign ylim = y_lo ? y_min : y_max;
  assign y_go = (y_lo || y_hi) && (wy != ty);

  assign w_moved_a = (ax != wx) || (ay != wy);
  assign w_moved_c = (cur_x != wx) || (cur_y != wy);

  always_comb begin
    if (state == ST_CUT_Y) begin
      sc_start = y_go;
      sc_d     = dif(tx, wx);
      sc_n     = dif(ylim, wy);
      sc_q     = dif(ty, wy);
    end else begin
      sc_start = (state == ST_CUT_X) && x_go;
      sc_d     = dif(ty, wy);
      sc_n     = dif(xlim, wx);
      sc_q     = dif(tx, wx);
    end
  end

  rpc_scale #(.MW(MW)) u_scale (
    .clk   (clk),
    .rst   (rst),
    .start (sc_start),
    .d     (sc_d),
    .n     (sc_n),
    .q     (sc_q),
    .done  (sc_done),
    .res   (sc_res)
  );

  assign in_ready       = (state == ST_IDLE);
  assign out_valid      = (state == ST_EMIT);
  assign out_x          = ent_x[emit_idx];
  assign out_y          = ent_y[emit_idx];
  assign point_valid    = ent_f[emit_idx].valid;
  assign starts_piece   = ent_f[emit_idx].start;
  assign ends_piece     = ent_f[emit_idx].stop;
  assign piece_interior = ring_r;
  assign position_mask  = mask_out;
  assign last_of_run    = (emit_idx == ent_n[1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      x_min        <= '0;
      y_min        <= '0;
      x_max        <= '0;
      y_max        <= '0;
      prev_x       <= '0;
      prev_y       <= '0;
      prev_class   <= '0;
      seen_mask    <= '0;
      first_vertex <= 1'b1;
      ent_n        <= '0;
      emit_idx     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          rpc_pkg::REG_X_MIN: x_min <= cfg_data;
          rpc_pkg::REG_Y_MIN: y_min <= cfg_data;
          rpc_pkg::REG_X_MAX: x_max <= cfg_data;
          rpc_pkg::REG_Y_MAX: y_max <= cfg_data;
          default: ;
        endcase
      end

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            cur_x  <= point_x;
            cur_y  <= point_y;
            last_r <= last_point;
            ring_r <= ring_interior;
            ent_n  <= '0;
            state  <= ST_PLAN;
          end
        end

        ST_PLAN: begin
          cur_cls <= cls_cur;
          state   <= ST_FINISH;
          if (first_vertex) begin
            seen_mask <= seen_mask | cls_cur;
            if (cls_cur == rpc_pkg::CLS_IN) begin
              ent_x[0] <= cur_x;
              ent_y[0] <= cur_y;
              ent_f[0] <= '{valid: 1'b1, start: 1'b1, stop: 1'b0};
              ent_n    <= 2'd1;
            end
          end else if (prev_class == rpc_pkg::CLS_IN) begin
            seen_mask <= seen_mask | cls_cur;
            if (cls_cur == rpc_pkg::CLS_OUT) begin
              wx    <= cur_x;
              wy    <= cur_y;
              tx    <= prev_x;
              ty    <= prev_y;
              use_r <= U_IN_OUT;
              state <= ST_CUT_X;
            end else begin
              ent_x[0] <= cur_x;
              ent_y[0] <= cur_y;
              ent_f[0] <= '{valid: 1'b1, start: 1'b0, stop: (cls_cur != rpc_pkg::CLS_IN)};
              ent_n    <= 2'd1;
            end
          end else if (prev_class == rpc_pkg::CLS_OUT) begin
            seen_mask <= seen_mask | cls_cur;
            wx <= prev_x;
            wy <= prev_y;
            tx <= cur_x;
            ty <= cur_y;
            if (cls_cur == rpc_pkg::CLS_OUT) begin
              // segments with both ends past one side are rejected at once
              if ((sides(prev_x, prev_y) & sides(cur_x, cur_y)) == '0) begin
                use_r <= U_OO_A;
                state <= ST_CUT_X;
              end
            end else begin
              use_r <= (cls_cur == rpc_pkg::CLS_IN) ? U_OUT_IN : U_OUT_EDGE;
              state <= ST_CUT_X;
            end
          end else begin
            if (cls_cur == rpc_pkg::CLS_OUT) begin
              seen_mask <= seen_mask | cls_cur;
              wx    <= cur_x;
              wy    <= cur_y;
              tx    <= prev_x;
              ty    <= prev_y;
              use_r <= U_EDGE_OUT;
              state <= ST_CUT_X;
            end else if (cls_cur == rpc_pkg::CLS_IN || !same_edge(prev_class, cls_cur)) begin
              // edge to inside, or edge to a different edge
              seen_mask <= seen_mask | cls_cur | rpc_pkg::CLS_IN;
              ent_x[0]  <= prev_x;
              ent_y[0]  <= prev_y;
              ent_f[0]  <= '{valid: 1'b1, start: 1'b1, stop: 1'b0};
              ent_x[1]  <= cur_x;
              ent_y[1]  <= cur_y;
              ent_f[1]  <= '{valid: 1'b1, start: 1'b0, stop: (cls_cur != rpc_pkg::CLS_IN)};
              ent_n     <= 2'd2;
            end else begin
              seen_mask <= seen_mask | cls_cur;
            end
          end
        end

        ST_CUT_X: begin
          if (x_go) begin
            lim_r <= xlim;
            state <= ST_CUT_XW;
          end else begin
            state <= ST_CUT_Y;
          end
        end

        ST_CUT_XW: begin
          if (sc_done) begin
            wy    <= wy + sc_res[W-1:0];
            wx    <= lim_r;
            state <= ST_CUT_Y;
          end
        end

        ST_CUT_Y: begin
          if (y_go) begin
            lim_r <= ylim;
            state <= ST_CUT_YW;
          end else begin
            state <= ST_POST;
          end
        end

        ST_CUT_YW: begin
          if (sc_done) begin
            wx    <= wx + sc_res[W-1:0];
            wy    <= lim_r;
            state <= ST_POST;
          end
        end

        ST_POST: begin
          state <= ST_FINISH;
          case (use_r)
            U_IN_OUT: begin
              ent_x[0] <= wx;
              ent_y[0] <= wy;
              ent_f[0] <= '{valid: 1'b1, start: 1'b0, stop: 1'b1};
              ent_n    <= 2'd1;
            end
            U_OO_A: begin
              // near cut on the boundary: cut the far end back toward it
              if (is_edge(cls_w)) begin
                ax     <= wx;
                ay     <= wy;
                pa_cls <= cls_w;
                wx     <= cur_x;
                wy     <= cur_y;
                tx     <= wx;
                ty     <= wy;
                use_r  <= U_OO_B;
                state  <= ST_CUT_X;
              end
            end
            U_OO_B: begin
              if (w_moved_a && is_edge(cls_w) && !same_edge(pa_cls, cls_w)) begin
                ent_x[0]  <= ax;
                ent_y[0]  <= ay;
                ent_f[0]  <= '{valid: 1'b1, start: 1'b1, stop: 1'b0};
                ent_x[1]  <= wx;
                ent_y[1]  <= wy;
                ent_f[1]  <= '{valid: 1'b1, start: 1'b0, stop: 1'b1};
                ent_n     <= 2'd2;
                seen_mask <= seen_mask | rpc_pkg::CLS_IN;
              end
            end
            U_OUT_IN: begin
              ent_x[0] <= wx;
              ent_y[0] <= wy;
              ent_f[0] <= '{valid: 1'b1, start: 1'b1, stop: 1'b0};
              ent_x[1] <= cur_x;
              ent_y[1] <= cur_y;
              ent_f[1] <= '{valid: 1'b1, start: 1'b0, stop: 1'b0};
              ent_n    <= 2'd2;
            end
            U_OUT_EDGE: begin
              if (!same_edge(cur_cls, cls_w)) begin
                ent_x[0]  <= wx;
                ent_y[0]  <= wy;
                ent_f[0]  <= '{valid: 1'b1, start: 1'b1, stop: 1'b0};
                ent_x[1]  <= cur_x;
                ent_y[1]  <= cur_y;
                ent_f[1]  <= '{valid: 1'b1, start: 1'b0, stop: 1'b1};
                ent_n     <= 2'd2;
                seen_mask <= seen_mask | rpc_pkg::CLS_IN;
              end
            end
            U_EDGE_OUT: begin
              if (w_moved_c && !same_edge(prev_class, cls_w)) begin
                ent_x[0] <= prev_x;
                ent_y[0] <= prev_y;
                ent_f[0] <= '{valid: 1'b1, start: 1'b1, stop: 1'b0};
                ent_x[1] <= wx;
                ent_y[1] <= wy;
                ent_f[1] <= '{valid: 1'b1, start: 1'b0, stop: 1'b1};
                ent_n    <= 2'd2;
              end
            end
            default: begin
              state <= ST_FINISH;
            end
          endcase
        end

        ST_FINISH: begin
          if (last_r && cur_cls == rpc_pkg::CLS_IN && ent_n != 2'd0) begin
            ent_f[ent_n[1]].stop <= 1'b1;
          end
          if (ent_n == 2'd0 && last_r) begin
            // status-only word
            ent_x[0] <= '0;
            ent_y[0] <= '0;
            ent_f[0] <= '{valid: 1'b0, start: 1'b0, stop: 1'b0};
            ent_n    <= 2'd1;
          end
          mask_out     <= seen_mask;
          prev_x       <= cur_x;
          prev_y       <= cur_y;
          prev_class   <= cur_cls;
          first_vertex <= last_r;
          if (last_r) begin
            seen_mask <= '0;
          end
          emit_idx <= 1'b0;
          state    <= (ent_n != 2'd0 || last_r) ? ST_EMIT : ST_IDLE;
        end

        ST_EMIT: begin
          if (out_ready) begin
            if (emit_idx == ent_n[1]) begin
              state <= ST_IDLE;
            end else begin
              emit_idx <= 1'b1;
            end
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/rpc_checker.sv =====
// rpc_checker: port-level checks for rect_polyline_clipper_unit
// bound to the top level below; uses rpc_pkg
module rpc_checker #(
  parameter int W = 32
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [W-1:0]        out_x,
  input logic signed [W-1:0]        out_y,
  input logic                       point_valid,
  input logic                       starts_piece,
  input logic                       ends_piece,
  input logic [rpc_pkg::MASK_W-1:0] position_mask,
  input logic                       last_of_run
);

  // a waiting result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y))
    else $error("result word changed while stalled");

  // status words only close a run and carry no coordinates
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && !point_valid |-> last_of_run && out_x == '0 && out_y == '0
      && !starts_piece && !ends_piece)
    else $error("malformed status word");

  // a one-point piece only comes from an inside vertex
  a_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && point_valid && starts_piece && ends_piece
      |-> (position_mask & rpc_pkg::CLS_IN) != '0 && last_of_run)
    else $error("single-point piece without inside vertex");

  // no new vertex is taken while results are pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid)
    else $error("input ready while emitting");

endmodule

bind rect_polyline_clipper_unit rpc_checker #(.W(COORD_WIDTH)) u_rpc_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_x         (out_x),
  .out_y         (out_y),
  .point_valid   (point_valid),
  .starts_piece  (starts_piece),
  .ends_piece    (ends_piece),
  .position_mask (position_mask),
  .last_of_run   (last_of_run)
);

// ===== verif/tb.sv =====
// tb: self-checking testbench for rect_polyline_clipper_unit
// predicts clipped point words for each vertex and compares them with the block output
// depends on rpc_pkg and rect_polyline_clipper_unit
module tb;

  localparam int CW = 32;
  localparam int WATCHDOG = 20000;

  typedef struct {
    logic signed [CW-1:0]       x;
    logic signed [CW-1:0]       y;
    logic                       pv;
    logic                       st;
    logic                       en;
    logic                       ring;
    logic [rpc_pkg::MASK_W-1:0] mask;
    logic                       lst;
  } clip_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [rpc_pkg::CFG_IDX_W-1:0] cfg_index = rpc_pkg::REG_X_MIN;
  logic [CW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [CW-1:0] point_x = '0;
  logic signed [CW-1:0] point_y = '0;
  logic last_point = 1'b0;
  logic ring_interior = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [CW-1:0] out_x, out_y;
  logic point_valid, starts_piece, ends_piece, piece_interior, last_of_run;
  logic [rpc_pkg::MASK_W-1:0] position_mask;

  rect_polyline_clipper_unit #(.COORD_WIDTH(CW)) dut (.*);

  always #4 clk = ~clk;

  // predictor state
  longint rx0, ry0, rx1, ry1;
  longint last_x, last_y;
  logic [rpc_pkg::MASK_W-1:0] last_cls, acc_mask;
  bit fresh_line;

  clip_word_t pending_words[$];
  int errors = 0;
  int words_seen = 0;
  int vertices_sent = 0;
  int idle_cycles = 0;
  bit out_stall_long = 0;

  function automatic longint sx(logic [CW-1:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic logic [rpc_pkg::MASK_W-1:0] vertex_class(longint x, longint y);
    logic [rpc_pkg::MASK_W-1:0] c;
    c = '0;
    if (x > rx0 && x < rx1 && y > ry0 && y < ry1) return rpc_pkg::CLS_IN;
    if (x < rx0 || x > rx1 || y < ry0 || y > ry1) return rpc_pkg::CLS_OUT;
    if (x == rx0) c |= rpc_pkg::CLS_LEFT;
    else if (x == rx1) c |= rpc_pkg::CLS_RIGHT;
    if (y == ry0) c |= rpc_pkg::CLS_BOTTOM;
    else if (y == ry1) c |= rpc_pkg::CLS_TOP;
    return c;
  endfunction

  function automatic logic [3:0] outcode(longint x, longint y);
    return {y > ry1, y < ry0, x > rx1, x < rx0};
  endfunction

  function automatic bit share_edge(logic [rpc_pkg::MASK_W-1:0] a,
                                    logic [rpc_pkg::MASK_W-1:0] b);
    return (a & b) > rpc_pkg::CLS_OUT;
  endfunction

  // trunc(d*n/q) with magnitude clamped to |d|
  function automatic longint interp(longint d, longint n, longint q);
    logic [127:0] ad, an, aq, res;
    bit neg;
    ad = d < 0 ? -d : d;
    an = n < 0 ? -n : n;
    aq = q < 0 ? -q : q;
    neg = ((d < 0) != (n < 0)) != (q < 0);
    if (an >= aq) res = ad;
    else res = (ad * an) / aq;
    return neg ? -longint'(res[63:0]) : longint'(res[63:0]);
  endfunction

  task automatic cut_axis(inout longint a1, inout longint b1, input longint a2,
                          input longint b2, input longint lim);
    if (a1 != a2) begin
      b1 += interp(b2 - b1, lim - a1, a2 - a1);
      a1 = lim;
    end
  endtask

  task automatic pull_in(inout longint x1, inout longint y1, input longint x2,
                         input longint y2);
    if (x1 < rx0) cut_axis(x1, y1, x2, y2, rx0);
    else if (x1 > rx1) cut_axis(x1, y1, x2, y2, rx1);
    if (y1 < ry0) cut_axis(y1, x1, y2, x2, ry0);
    else if (y1 > ry1) cut_axis(y1, x1, y2, x2, ry1);
  endtask

  task automatic predict_vertex(logic [CW-1:0] px, logic [CW-1:0] py, logic lst,
                                logic ring);
    longint x, y, ax, ay, bx, by, cx, cy;
    longint qx[$], qy[$];
    bit qs[$], qe[$];
    logic [rpc_pkg::MASK_W-1:0] cur, pa, pb;
    clip_word_t w;
    x = sx(px);
    y = sx(py);
    cur = vertex_class(x, y);
    acc_mask |= cur;
    if (fresh_line) begin
      if (cur == rpc_pkg::CLS_IN) begin
        qx.push_back(x); qy.push_back(y); qs.push_back(1); qe.push_back(0);
      end
    end else if (last_cls == rpc_pkg::CLS_IN) begin
      if (cur == rpc_pkg::CLS_IN) begin
        qx.push_back(x); qy.push_back(y); qs.push_back(0); qe.push_back(0);
      end else if (cur == rpc_pkg::CLS_OUT) begin
        cx = x; cy = y;
        pull_in(cx, cy, last_x, last_y);
        qx.push_back(cx); qy.push_back(cy); qs.push_back(0); qe.push_back(1);
      end else begin
        qx.push_back(x); qy.push_back(y); qs.push_back(0); qe.push_back(1);
      end
    end else if (last_cls == rpc_pkg::CLS_OUT) begin
      ax = last_x; ay = last_y;
      if (cur == rpc_pkg::CLS_OUT) begin
        if ((outcode(last_x, last_y) & outcode(x, y)) == 0) begin
          pull_in(ax, ay, x, y);
          pa = vertex_class(ax, ay);
          if (pa > rpc_pkg::CLS_OUT) begin
            bx = x; by = y;
            pull_in(bx, by, ax, ay);
            pb = vertex_class(bx, by);
            if ((ax != bx || ay != by) && pb > rpc_pkg::CLS_OUT && !share_edge(pa, pb)) begin
              qx.push_back(ax); qy.push_back(ay); qs.push_back(1); qe.push_back(0);
              qx.push_back(bx); qy.push_back(by); qs.push_back(0); qe.push_back(1);
              acc_mask |= rpc_pkg::CLS_IN;
            end
          end
        end
      end else if (cur == rpc_pkg::CLS_IN) begin
        pull_in(ax, ay, x, y);
        qx.push_back(ax); qy.push_back(ay); qs.push_back(1); qe.push_back(0);
        qx.push_back(x); qy.push_back(y); qs.push_back(0); qe.push_back(0);
      end else begin
        pull_in(ax, ay, x, y);
        if (!share_edge(cur, vertex_class(ax, ay))) begin
          qx.push_back(ax); qy.push_back(ay); qs.push_back(1); qe.push_back(0);
          qx.push_back(x); qy.push_back(y); qs.push_back(0); qe.push_back(1);
          acc_mask |= rpc_pkg::CLS_IN;
        end
      end
    end else begin
      if (cur == rpc_pkg::CLS_IN) begin
        qx.push_back(last_x); qy.push_back(last_y); qs.push_back(1); qe.push_back(0);
        qx.push_back(x); qy.push_back(y); qs.push_back(0); qe.push_back(0);
      end else if (cur == rpc_pkg::CLS_OUT) begin
        cx = x; cy = y;
        pull_in(cx, cy, last_x, last_y);
        if ((cx != x || cy != y) && !share_edge(last_cls, vertex_class(cx, cy))) begin
          qx.push_back(last_x); qy.push_back(last_y); qs.push_back(1); qe.push_back(0);
          qx.push_back(cx); qy.push_back(cy); qs.push_back(0); qe.push_back(1);
        end
      end else if (!share_edge(last_cls, cur)) begin
        qx.push_back(last_x); qy.push_back(last_y); qs.push_back(1); qe.push_back(0);
        qx.push_back(x); qy.push_back(y); qs.push_back(0); qe.push_back(1);
        acc_mask |= rpc_pkg::CLS_IN;
      end
    end
    if (lst && cur == rpc_pkg::CLS_IN && qx.size() > 0) qe[qx.size()-1] = 1;
    for (int k = 0; k < qx.size(); k++) begin
      w.x = qx[k][CW-1:0]; w.y = qy[k][CW-1:0];
      w.pv = 1; w.st = qs[k]; w.en = qe[k];
      w.ring = ring; w.mask = acc_mask; w.lst = (k == qx.size() - 1);
      pending_words.push_back(w);
    end
    if (qx.size() == 0 && lst) begin
      w.x = '0; w.y = '0; w.pv = 0; w.st = 0; w.en = 0;
      w.ring = ring; w.mask = acc_mask; w.lst = 1;
      pending_words.push_back(w);
    end
    last_x = x; last_y = y; last_cls = cur;
    fresh_line = lst;
    if (lst) acc_mask = '0;
  endtask

  // result checker
  always @(posedge clk) begin
    clip_word_t e;
    if (!rst && out_valid && out_ready) begin
      words_seen++;
      if (pending_words.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word x=%0d y=%0d", out_x, out_y);
      end else begin
        e = pending_words.pop_front();
        if (out_x !== e.x || out_y !== e.y || point_valid !== e.pv ||
            starts_piece !== e.st || ends_piece !== e.en || piece_interior !== e.ring ||
            position_mask !== e.mask || last_of_run !== e.lst) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch: exp x=%0d y=%0d v%0b s%0b e%0b r%0b m%02h l%0b",
              e.x, e.y, e.pv, e.st, e.en, e.ring, e.mask, e.lst);
            $display("          got x=%0d y=%0d v%0b s%0b e%0b r%0b m%02h l%0b",
              out_x, out_y, point_valid, starts_piece, ends_piece, piece_interior,
              position_mask, last_of_run);
          end
        end
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    if (out_stall_long) out_ready <= ($urandom_range(0, 9) == 0);
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  // watchdog on accepted traffic
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("watchdog expired");
      $display("** rect_polyline_clipper_unit: FAILED **");
      $finish;
    end
  end

  task automatic send_vertex(longint x, longint y, bit lst, bit ring);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    // the previous word drops valid on this falling edge, so raise it on a later one
    repeat (gap + 1) @(negedge clk);
    predict_vertex(x[CW-1:0], y[CW-1:0], lst, ring);
    in_valid <= 1'b1;
    point_x <= x[CW-1:0];
    point_y <= y[CW-1:0];
    last_point <= lst;
    ring_interior <= ring;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    vertices_sent++;
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic set_rect(longint a, longint b, longint c, longint d);
    longint v[4];
    v = '{a, b, c, d};
    drain();
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= i[rpc_pkg::CFG_IDX_W-1:0];
      cfg_data <= v[i][CW-1:0];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    rx0 = a; ry0 = b; rx1 = c; ry1 = d;
  endtask

  function automatic longint rnd_coord(longint lo, longint hi);
    longint span;
    span = hi - lo;
    case ($urandom_range(0, 9))
      0: return lo;
      1: return hi;
      2: return -64'sd2147483648;
      3: return 64'sd2147483647;
      4: return longint'(signed'(32'($urandom())));
      default: return lo - span / 2 + longint'($urandom_range(0, 1000)) * (2 * span) / 1000;
    endcase
  endfunction

  task automatic test_directed;
    set_rect(-32'sh10000, -32'sh10000, 32'sh10000, 32'sh10000);
    send_vertex(0, 0, 1, 0);                       // lone inside vertex
    send_vertex(-32'sh20000, 0, 0, 1);             // crossing both sides
    send_vertex(32'sh20000, 0, 1, 1);
    send_vertex(-32'sh20000, 32'sh20000, 0, 0);    // common side, rejected
    send_vertex(32'sh20000, 32'sh20000, 1, 0);
    send_vertex(-32'sh10000, -32'sh10000, 0, 0);   // run along left edge
    send_vertex(-32'sh10000, 32'sh10000, 0, 0);
    send_vertex(0, 32'sh8000, 0, 1);               // edge to inside
    send_vertex(32'sh10000, 0, 0, 1);              // inside to edge
    send_vertex(32'sh30000, 32'sh5000, 1, 1);      // leave from edge
    send_vertex(-32'sh20000, 0, 0, 0);             // corner touch
    send_vertex(0, 32'sh20000, 1, 0);
    send_vertex(-64'sd2147483648, -64'sd2147483648, 0, 0);
    send_vertex(64'sd2147483647, 64'sd2147483647, 1, 1);
    send_vertex(32'sh20000, 32'sh20000, 1, 0);     // status only
  endtask

  task automatic test_hold_off;
    drain();
    send_vertex(32'sh100, 32'sh100, 0, 0);
    send_vertex(-32'sh30000, 32'sh100, 1, 1);
  endtask

  task automatic random_lines(int n, longint lo, longint hi);
    int len, cnt;
    cnt = 0;
    while (cnt < n) begin
      len = $urandom_range(1, 8);
      for (int i = 0; i < len && cnt < n; i++) begin
        send_vertex(rnd_coord(lo, hi), rnd_coord(lo, hi), i == len - 1, $urandom_range(0, 1));
        cnt++;
      end
    end
  endtask

  task automatic test_random;
    set_rect(-32'sh40000, -32'sh40000, 32'sh40000, 32'sh40000);
    random_lines(160, -32'sh40000, 32'sh40000);
    out_stall_long = 1;
    set_rect(32'sh1000, -32'sh80000, 32'sh3000000, 32'sh2000);
    random_lines(100, -32'sh80000, 32'sh2000);
    out_stall_long = 0;
    set_rect(-64'sd2147483648, -64'sd2147483648, 64'sd2147483647, 64'sd2147483647);
    random_lines(80, -64'sd2147483648, 64'sd2147483647);
    set_rect(32'sh5000, 32'sh5000, 32'sh5000, 32'sh5000);  // degenerate
    random_lines(40, 32'sh4000, 32'sh6000);
    set_rect(32'sh9000, 32'sh9000, 32'sh1000, 32'sh1000);  // inverted
    random_lines(40, 32'sh1000, 32'sh9000);
    set_rect(-32'sh100, -32'sh100, 32'sh100, 32'sh100);
    random_lines(40, -32'sh200, 32'sh200);
  endtask

  initial begin
    rx0 = 0; ry0 = 0; rx1 = 0; ry1 = 0;
    last_x = 0; last_y = 0; last_cls = '0; acc_mask = '0; fresh_line = 1;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_hold_off();
    test_random();
    while (pending_words.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    $display("sent %0d vertices over seven rectangles, %0d words checked", vertices_sent,
      words_seen);
    $display("covered crossings, edge runs, corners, degenerate and inverted rectangles");
    if (errors == 0) $display("** rect_polyline_clipper_unit: PASSED **");
    else $display("** rect_polyline_clipper_unit: FAILED **");
    $finish;
  end

endmodule
